/* hw/rtl/umrt_pkg.sv */
package umrt_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam int ID_W      = 32;
    localparam int HANDLE_W  = 8;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 3;

    // Command codes carried by s_command.
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // Event codes carried by m_event_kind.
    localparam logic [KIND_W-1:0] EV_FIRST   = 3'd0;
    localparam logic [KIND_W-1:0] EV_RETX    = 3'd1;
    localparam logic [KIND_W-1:0] EV_ACK_OK  = 3'd2;
    localparam logic [KIND_W-1:0] EV_ACK_IGN = 3'd3;
    localparam logic [KIND_W-1:0] EV_REJECT  = 3'd4;

    // Per-cycle operation strobes broadcast to every cell.
    typedef struct packed {
        logic do_send;
        logic do_ack;
        logic do_tick;
        logic do_pop;
    } umrt_ctl_t;

    // Priority flags that ripple from the lowest slot to the highest.
    typedef struct packed {
        logic free_seen;
        logic hit_seen;
        logic due_one;
        logic due_two;
    } umrt_chain_t;

endpackage

/* hw/rtl/umrt_cell.sv */
module umrt_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  umrt_pkg::umrt_ctl_t                   ctl,
    input  logic [umrt_pkg::ID_W-1:0]             op_id,
    input  logic [umrt_pkg::HANDLE_W-1:0]         op_handle,
    input  logic [umrt_pkg::TIME_W-1:0]           cur_time,
    input  logic [umrt_pkg::TIME_W-1:0]           next_time,
    input  logic [umrt_pkg::TIMEOUT_W-1:0]        timeout,
    input  umrt_pkg::umrt_chain_t                 chain_in,
    output umrt_pkg::umrt_chain_t                 chain_out,
    output logic [umrt_pkg::ID_W-1:0]             sel_id,
    output logic [umrt_pkg::HANDLE_W-1:0]         sel_handle
);

    logic                              valid_reg;
    logic                              due_reg;
    logic [umrt_pkg::ID_W-1:0]         id_reg;
    logic [umrt_pkg::HANDLE_W-1:0]     handle_reg;
    logic [umrt_pkg::TIME_W-1:0]       stamp_reg;

    logic                              hit;
    logic                              take_send;
    logic                              take_ack;
    logic                              take_pop;
    logic                              expired;
    logic [umrt_pkg::TIME_W-1:0]       age;

    assign hit       = valid_reg && (id_reg == op_id);
    assign take_send = !valid_reg && !chain_in.free_seen;
    assign take_ack  = hit && !chain_in.hit_seen;
    assign take_pop  = due_reg && !chain_in.due_one;

    // Age is taken modulo 2^32, so the stamp may lie on either side of a wrap.
    assign age     = next_time - stamp_reg;
    assign expired = valid_reg && (age > {{(umrt_pkg::TIME_W-umrt_pkg::TIMEOUT_W){1'b0}}, timeout});

    assign chain_out.free_seen = chain_in.free_seen || !valid_reg;
    assign chain_out.hit_seen  = chain_in.hit_seen || hit;
    assign chain_out.due_one   = chain_in.due_one || due_reg;
    assign chain_out.due_two   = chain_in.due_two || (chain_in.due_one && due_reg);

    assign sel_id     = take_pop ? id_reg : '0;
    assign sel_handle = take_pop ? handle_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            due_reg   <= 1'b0;
        end else begin
            if (ctl.do_send && take_send) begin
                valid_reg <= 1'b1;
            end else if (ctl.do_ack && take_ack) begin
                valid_reg <= 1'b0;
            end
            if (ctl.do_tick) begin
                due_reg <= expired;
            end else if (ctl.do_pop && take_pop) begin
                due_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.do_send && take_send) begin
            id_reg     <= op_id;
            handle_reg <= op_handle;
            stamp_reg  <= cur_time;
        end else if (ctl.do_tick && expired) begin
            stamp_reg  <= next_time;
        end
    end

endmodule

/* hw/rtl/unacked_message_retransmit_table.sv */
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_command, s_message_id, s_payload_handle
// m_        out        m_valid / m_ready      m_event_kind, m_out_message_id,
//                                             m_out_payload_handle, m_last_of_run
// cfg_      in         cfg_valid / cfg_ready  cfg_data (retransmit timeout)
//
// A send or an ack word is first captured; then the whole row of cells does its
// associative match and the result word is written.
// A tick is captured, then the cells latch their due flags and restamp, then the
// due entries are emitted in turn; the pace is set by the single output register
// the cells drain into in slot order.
// Reset is synchronous and active low; it clears all slot valid bits and the clock.
// A stalled m_ready holds a send, an ack or a scan step in place; s_ready rises again as soon
// as the previous word has reached the output register.
module unacked_message_retransmit_table (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [umrt_pkg::CMD_W-1:0]            s_command,
    input  logic [umrt_pkg::ID_W-1:0]             s_message_id,
    input  logic [umrt_pkg::HANDLE_W-1:0]         s_payload_handle,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [umrt_pkg::KIND_W-1:0]           m_event_kind,
    output logic [umrt_pkg::ID_W-1:0]             m_out_message_id,
    output logic [umrt_pkg::HANDLE_W-1:0]         m_out_payload_handle,
    output logic                                  m_last_of_run,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [umrt_pkg::TIMEOUT_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    state_t                                state_reg;

    // Captured input word.
    logic [umrt_pkg::CMD_W-1:0]            cmd_reg;
    logic [umrt_pkg::ID_W-1:0]             id_reg;
    logic [umrt_pkg::HANDLE_W-1:0]         handle_reg;

    logic [umrt_pkg::TIME_W-1:0]           time_reg;
    logic [umrt_pkg::TIMEOUT_W-1:0]        timeout_reg;

    // Output register.
    logic                                  m_valid_reg;
    logic [umrt_pkg::KIND_W-1:0]           kind_reg;
    logic [umrt_pkg::ID_W-1:0]             out_id_reg;
    logic [umrt_pkg::HANDLE_W-1:0]         out_handle_reg;
    logic                                  last_reg;

    logic                                  out_free;
    logic                                  out_load;
    logic [umrt_pkg::TIME_W-1:0]           next_time;
    umrt_pkg::umrt_ctl_t                   ctl;

    umrt_pkg::umrt_chain_t                 chain [umrt_pkg::TABLE_DEPTH+1];
    logic [umrt_pkg::ID_W-1:0]             cell_id     [umrt_pkg::TABLE_DEPTH];
    logic [umrt_pkg::HANDLE_W-1:0]         cell_handle [umrt_pkg::TABLE_DEPTH];
    logic [umrt_pkg::ID_W-1:0]             emit_id;
    logic [umrt_pkg::HANDLE_W-1:0]         emit_handle;

    logic                                  table_has_free;
    logic                                  ack_hit;
    logic                                  any_due;
    logic                                  last_due;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid              = m_valid_reg;
    assign m_event_kind         = kind_reg;
    assign m_out_message_id     = out_id_reg;
    assign m_out_payload_handle = out_handle_reg;
    assign m_last_of_run        = last_reg;

    // The output register can take a new word when it is empty or being drained.
    assign out_free  = !m_valid_reg || m_ready;
    assign next_time = time_reg + 1'b1;

    always_comb begin
        ctl.do_send = (state_reg == ST_EXEC) && (cmd_reg == umrt_pkg::CMD_SEND) && out_free;
        ctl.do_ack  = (state_reg == ST_EXEC) && (cmd_reg == umrt_pkg::CMD_ACK) && out_free;
        ctl.do_tick = (state_reg == ST_EXEC) && (cmd_reg == umrt_pkg::CMD_TICK);
        ctl.do_pop  = (state_reg == ST_SCAN) && out_free && any_due;
    end

    // A new result word enters the output register in exactly these cycles.
    assign out_load = ctl.do_send || ctl.do_ack || ctl.do_pop;

    // The lowest slot sees no earlier candidates.
    assign chain[0] = '0;

    for (genvar g = 0; g < umrt_pkg::TABLE_DEPTH; g++) begin : g_cell
        umrt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .op_id      (id_reg),
            .op_handle  (handle_reg),
            .cur_time   (time_reg),
            .next_time  (next_time),
            .timeout    (timeout_reg),
            .chain_in   (chain[g]),
            .chain_out  (chain[g+1]),
            .sel_id     (cell_id[g]),
            .sel_handle (cell_handle[g])
        );
    end

    assign table_has_free = chain[umrt_pkg::TABLE_DEPTH].free_seen;
    assign ack_hit        = chain[umrt_pkg::TABLE_DEPTH].hit_seen;
    assign any_due        = chain[umrt_pkg::TABLE_DEPTH].due_one;
    // The popped entry is the last one when no second pending entry exists.
    assign last_due       = !chain[umrt_pkg::TABLE_DEPTH].due_two;

    // At most one cell drives nonzero data, so an OR collects the selected entry.
    always_comb begin
        emit_id     = '0;
        emit_handle = '0;
        for (int i = 0; i < umrt_pkg::TABLE_DEPTH; i++) begin
            emit_id     = emit_id | cell_id[i];
            emit_handle = emit_handle | cell_handle[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 16'd2;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg    <= s_command;
                        id_reg     <= s_message_id;
                        handle_reg <= s_payload_handle;
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (cmd_reg)
                        umrt_pkg::CMD_SEND: begin
                            if (out_free) begin
                                kind_reg       <= table_has_free ? umrt_pkg::EV_FIRST
                                                                 : umrt_pkg::EV_REJECT;
                                out_id_reg     <= id_reg;
                                out_handle_reg <= handle_reg;
                                last_reg       <= 1'b1;
                                state_reg      <= ST_IDLE;
                            end
                        end
                        umrt_pkg::CMD_ACK: begin
                            if (out_free) begin
                                kind_reg       <= ack_hit ? umrt_pkg::EV_ACK_OK
                                                          : umrt_pkg::EV_ACK_IGN;
                                out_id_reg     <= id_reg;
                                out_handle_reg <= '0;
                                last_reg       <= 1'b1;
                                state_reg      <= ST_IDLE;
                            end
                        end
                        umrt_pkg::CMD_TICK: begin
                            // Cells latch their due flags and restamp in this cycle.
                            time_reg  <= next_time;
                            state_reg <= ST_SCAN;
                        end
                        default: begin
                            // The unused command code changes nothing.
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_SCAN: begin
                    if (out_free) begin
                        if (any_due) begin
                            kind_reg       <= umrt_pkg::EV_RETX;
                            out_id_reg     <= emit_id;
                            out_handle_reg <= emit_handle;
                            last_reg       <= last_due;
                            if (last_due) begin
                                state_reg <= ST_IDLE;
                            end
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
